// File: rtl/core/hod_pkg.sv
// ----------------------------------------------------------------------------
// hod_pkg
// Shared types and constants of the host overload detector.
// ----------------------------------------------------------------------------
package hod_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam int SW_W    = 8;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int CNT_W   = 24;
    localparam int RUN_W   = 8;
    localparam int TIME_W  = 32;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0]  THRESHOLD_RST = 24'd1000;
    localparam logic [RUN_W-1:0]  START_RST     = 8'd3;
    localparam logic [RUN_W-1:0]  STOP_RST      = 8'd6;
    localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd300;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [RUN_W-1:0] RUN_MAX = '1;
    localparam logic [MAC_W-1:0] MAC_BCAST = '1;

    localparam logic [ACT_W-1:0] ACT_DONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSTALL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DROP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd3;

    typedef struct packed {
        logic [SW_W-1:0]   sw;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [CNT_W-1:0]  count;
        logic [RUN_W-1:0]  orun;
        logic [RUN_W-1:0]  qrun;
        logic              blocked;
        logic [TIME_W-1:0] stamp;
    } entry_t;

endpackage

// File: rtl/core/host_overload_detector.sv
// ----------------------------------------------------------------------------
// host_overload_detector
// Per-host message rate monitor with hysteresis blocking over a host table.
// ----------------------------------------------------------------------------
// Channel | Handshake             | Payload
// input   | start / busy          | mode, switch_id, switch_ready, host_ip,
//         |                       | host_mac, now_seconds
// result  | result_valid (strobe) | action, out_switch, out_ip, out_mac, last
// config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The table sits in one memory; each entry is read, then evaluated and
// written back. A message walks the table and ends early on a hit; an
// ignored message leaves the block idle. A tick walks every entry and
// gives at most one result per entry plus done. Reset clears only the
// valid bits; no clearing pass is needed.
// Results cannot be stalled; each is shown for one cycle.
module host_overload_detector #(
    parameter int TABLE_DEPTH = hod_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [hod_pkg::SW_W-1:0]          switch_id,
    input  logic                              switch_ready,
    input  logic [hod_pkg::IP_W-1:0]          host_ip,
    input  logic [hod_pkg::MAC_W-1:0]         host_mac,
    input  logic [hod_pkg::TIME_W-1:0]        now_seconds,
    output logic                              result_valid,
    output logic [hod_pkg::ACT_W-1:0]         action,
    output logic [hod_pkg::SW_W-1:0]          out_switch,
    output logic [hod_pkg::IP_W-1:0]          out_ip,
    output logic [hod_pkg::MAC_W-1:0]         out_mac,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hod_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hod_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic              mode_reg;
    logic [SW_W-1:0]   sw_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [TIME_W-1:0] now_reg;

    logic [CNT_W-1:0]  thr_reg;
    logic [RUN_W-1:0]  start_lim_reg;
    logic [RUN_W-1:0]  stop_lim_reg;
    logic [TIME_W-1:0] timeout_reg;

    logic              rv_reg, rv_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [SW_W-1:0]   osw_reg, osw_next;
    logic [IP_W-1:0]   oip_reg, oip_next;
    logic [MAC_W-1:0]  omac_reg, omac_next;
    logic              last_reg, last_next;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    entry_t            wdata;
    entry_t            upd;
    logic              emit_inst, emit_rem, free_it;
    logic              key_hit, ignored, any_free;
    logic [IDX_W-1:0]  free_idx;
    logic [TIME_W-1:0] age;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign result_valid = rv_reg;
    assign action       = act_reg;
    assign out_switch   = osw_reg;
    assign out_ip       = oip_reg;
    assign out_mac      = omac_reg;
    assign last         = last_reg;

    assign ignored = !switch_ready || (host_ip == '0) || (host_mac == '0)
                     || (host_mac == MAC_BCAST);

    assign key_hit = (rdata_reg.sw == sw_reg) && (rdata_reg.ip == ip_reg)
                     && (rdata_reg.mac == mac_reg);

    // Lowest free slot.
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Tick update of one entry.
    always_comb
    begin
        upd       = rdata_reg;
        emit_inst = 1'b0;
        emit_rem  = 1'b0;
        if (rdata_reg.count >= thr_reg)
        begin
            if (rdata_reg.orun != RUN_MAX)
                upd.orun = rdata_reg.orun + 1'b1;
            upd.qrun = '0;
            if (upd.orun >= start_lim_reg)
            begin
                upd.blocked = 1'b1;
                upd.orun    = '0;
                emit_inst   = 1'b1;
            end
        end
        else
        begin
            upd.orun = '0;
            if (rdata_reg.blocked)
            begin
                if (rdata_reg.qrun != RUN_MAX)
                    upd.qrun = rdata_reg.qrun + 1'b1;
                if (upd.qrun >= stop_lim_reg)
                begin
                    upd.blocked = 1'b0;
                    upd.qrun    = '0;
                    emit_rem    = 1'b1;
                end
            end
        end
        age     = now_reg - rdata_reg.stamp;
        free_it = 1'b0;
        if (rdata_reg.count != '0)
            upd.stamp = now_reg;
        else if (age >= timeout_reg)
            free_it = 1'b1;
        upd.count = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = rdata_reg;
        rv_next    = 1'b0;
        act_next   = act_reg;
        osw_next   = osw_reg;
        oip_next   = oip_reg;
        omac_next  = omac_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && (mode || !ignored))
                begin
                    idx_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                state_next = (idx_reg == IDX_LAST) ? (mode_reg ? S_DONE : S_FIN) : S_RD;
                idx_next   = idx_reg + 1'b1;
                if (valid_reg[idx_reg])
                begin
                    if (!mode_reg)
                    begin
                        if (key_hit)
                        begin
                            we = 1'b1;
                            if (rdata_reg.count != CNT_MAX)
                                wdata.count = rdata_reg.count + 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = upd;
                        if (free_it)
                            valid_next[idx_reg] = 1'b0;
                        if (emit_inst || emit_rem)
                        begin
                            rv_next   = 1'b1;
                            act_next  = emit_inst ? ACT_INSTALL : ACT_REMOVE;
                            osw_next  = rdata_reg.sw;
                            oip_next  = rdata_reg.ip;
                            omac_next = rdata_reg.mac;
                            last_next = 1'b0;
                        end
                    end
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
                if (any_free)
                begin
                    we            = 1'b1;
                    waddr         = free_idx;
                    wdata.sw      = sw_reg;
                    wdata.ip      = ip_reg;
                    wdata.mac     = mac_reg;
                    wdata.count   = CNT_W'(1);
                    wdata.orun    = '0;
                    wdata.qrun    = '0;
                    wdata.blocked = 1'b0;
                    wdata.stamp   = now_reg;
                    valid_next[free_idx] = 1'b1;
                end
                else
                begin
                    rv_next   = 1'b1;
                    act_next  = ACT_DROP;
                    osw_next  = sw_reg;
                    oip_next  = ip_reg;
                    omac_next = mac_reg;
                    last_next = 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
                rv_next    = 1'b1;
                act_next   = ACT_DONE;
                osw_next   = '0;
                oip_next   = '0;
                omac_next  = '0;
                last_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            rv_reg        <= 1'b0;
            thr_reg       <= THRESHOLD_RST;
            start_lim_reg <= START_RST;
            stop_lim_reg  <= STOP_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            rv_reg    <= rv_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_THRESHOLD)
                    thr_reg <= cfg_data[CNT_W-1:0];
                else if (cfg_index == REG_START)
                    start_lim_reg <= cfg_data[RUN_W-1:0];
                else if (cfg_index == REG_STOP)
                    stop_lim_reg <= cfg_data[RUN_W-1:0];
                else if (cfg_index == REG_TIMEOUT)
                    timeout_reg <= cfg_data[TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode;
            sw_reg   <= switch_id;
            ip_reg   <= host_ip;
            mac_reg  <= host_mac;
            now_reg  <= now_seconds;
        end
        act_reg  <= act_next;
        osw_reg  <= osw_next;
        oip_reg  <= oip_next;
        omac_reg <= omac_next;
        last_reg <= last_next;
    end

endmodule

// File: rtl/core/hod_checker.sv
// ----------------------------------------------------------------------------
// hod_checker
// Port-level checks of the host overload detector, bound to the top level.
// ----------------------------------------------------------------------------
module hod_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          busy,
    input logic                          result_valid,
    input logic [hod_pkg::ACT_W-1:0]     action,
    input logic [hod_pkg::SW_W-1:0]      out_switch,
    input logic [hod_pkg::IP_W-1:0]      out_ip,
    input logic [hod_pkg::MAC_W-1:0]     out_mac,
    input logic                          last
);
    import hod_pkg::*;

    // Every result belongs to an item that was in progress in the previous cycle.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without an item in progress");

    // Install and remove beats are never the final beat of an item; done and drop beats always are.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last == ((action == ACT_DONE) || (action == ACT_DROP))))
        else $error("last flag does not match action");

    // The done beat carries an all-zero key.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && action == ACT_DONE) |->
            (out_switch == '0 && out_ip == '0 && out_mac == '0))
        else $error("done beat with nonzero key");

    // A final beat frees the block.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("still busy after the final beat");

endmodule

bind host_overload_detector hod_checker u_hod_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .action       (action),
    .out_switch   (out_switch),
    .out_ip       (out_ip),
    .out_mac      (out_mac),
    .last         (last)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for host_overload_detector. A queue of host messages
// and ticks feeds a driver that idles at random. Each accepted beat runs
// through a host-table predictor kept in the bench. A monitor compares every
// result strobe with the oldest expected action. Several register settings
// are visited, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hod_pkg::*;

    localparam int DEPTH      = 32;
    localparam int SETTLE_CYC = 2 * DEPTH + 8;
    localparam int WDOG_LIMIT = 4000;
    localparam int NKEYS      = 40;

    typedef struct {
        bit              mode;
        bit [SW_W-1:0]   sw;
        bit              rdy;
        bit [IP_W-1:0]   ip;
        bit [MAC_W-1:0]  mac;
        bit [TIME_W-1:0] now;
    } host_item_t;

    typedef struct {
        bit [ACT_W-1:0]  act;
        bit [SW_W-1:0]   sw;
        bit [IP_W-1:0]   ip;
        bit [MAC_W-1:0]  mac;
        bit              last;
    } host_action_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  mode;
    logic [SW_W-1:0]       switch_id;
    logic                  switch_ready;
    logic [IP_W-1:0]       host_ip;
    logic [MAC_W-1:0]      host_mac;
    logic [TIME_W-1:0]     now_seconds;
    logic                  result_valid;
    logic [ACT_W-1:0]      action;
    logic [SW_W-1:0]       out_switch;
    logic [IP_W-1:0]       out_ip;
    logic [MAC_W-1:0]      out_mac;
    logic                  last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    host_overload_detector dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .switch_id(switch_id), .switch_ready(switch_ready), .host_ip(host_ip),
        .host_mac(host_mac), .now_seconds(now_seconds),
        .result_valid(result_valid), .action(action), .out_switch(out_switch),
        .out_ip(out_ip), .out_mac(out_mac), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Bench copy of the registers and the host table.
    bit [CNT_W-1:0]  thr_q;
    bit [RUN_W-1:0]  start_lim_q;
    bit [RUN_W-1:0]  stop_lim_q;
    bit [TIME_W-1:0] timeout_q;
    bit              hv [DEPTH];
    bit [SW_W-1:0]   hsw [DEPTH];
    bit [IP_W-1:0]   hip [DEPTH];
    bit [MAC_W-1:0]  hmac [DEPTH];
    bit [CNT_W-1:0]  hcnt [DEPTH];
    bit [RUN_W-1:0]  horun [DEPTH];
    bit [RUN_W-1:0]  hqrun [DEPTH];
    bit              hblk [DEPTH];
    bit [TIME_W-1:0] hstamp [DEPTH];

    host_item_t   host_items[$];
    host_action_t pending_actions[$];
    int           errors;
    int           beats_sent;
    bit           took;
    int           quiet_cycles;

    bit [SW_W-1:0]   key_sw [NKEYS];
    bit [IP_W-1:0]   key_ip [NKEYS];
    bit [MAC_W-1:0]  key_mac [NKEYS];
    bit [TIME_W-1:0] clock_s;

    function automatic void push_action(bit [ACT_W-1:0] a, bit [SW_W-1:0] s,
                                        bit [IP_W-1:0] ip, bit [MAC_W-1:0] m,
                                        bit l);
        host_action_t r;
        r.act = a; r.sw = s; r.ip = ip; r.mac = m; r.last = l;
        pending_actions.push_back(r);
    endfunction

    function automatic void predict_table_update(host_item_t it);
        int  slot;
        bit  hit;
        bit [RUN_W-1:0] st_eff;
        bit [RUN_W-1:0] sp_eff;
        slot = -1;
        hit = 0;
        st_eff = (start_lim_q == 0) ? 8'd1 : start_lim_q;
        sp_eff = (stop_lim_q == 0) ? 8'd1 : stop_lim_q;
        if (!it.mode) begin
            if (!it.rdy || it.ip == 0 || it.mac == 0 || it.mac == MAC_BCAST)
                return;
            for (int i = 0; i < DEPTH; i++) begin
                if (hit)
                    break;
                if (hv[i]) begin
                    if (hsw[i] == it.sw && hip[i] == it.ip && hmac[i] == it.mac) begin
                        if (hcnt[i] != CNT_MAX)
                            hcnt[i]++;
                        hit = 1;
                    end
                end
                else if (slot < 0) begin
                    slot = i;
                end
            end
            if (hit)
                return;
            if (slot < 0) begin
                push_action(ACT_DROP, it.sw, it.ip, it.mac, 1'b1);
                return;
            end
            hv[slot] = 1; hsw[slot] = it.sw; hip[slot] = it.ip; hmac[slot] = it.mac;
            hcnt[slot] = 1; horun[slot] = 0; hqrun[slot] = 0; hblk[slot] = 0;
            hstamp[slot] = it.now;
            return;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (!hv[i])
                continue;
            if (hcnt[i] >= thr_q) begin
                if (horun[i] != RUN_MAX)
                    horun[i]++;
                hqrun[i] = 0;
                if (horun[i] >= st_eff) begin
                    hblk[i] = 1;
                    horun[i] = 0;
                    push_action(ACT_INSTALL, hsw[i], hip[i], hmac[i], 1'b0);
                end
            end
            else begin
                horun[i] = 0;
                if (hblk[i]) begin
                    if (hqrun[i] != RUN_MAX)
                        hqrun[i]++;
                    if (hqrun[i] >= sp_eff) begin
                        hblk[i] = 0;
                        hqrun[i] = 0;
                        push_action(ACT_REMOVE, hsw[i], hip[i], hmac[i], 1'b0);
                    end
                end
            end
            if (hcnt[i] != 0) begin
                hstamp[i] = it.now;
            end
            else if (it.now - hstamp[i] >= timeout_q) begin
                hv[i] = 0;
                continue;
            end
            hcnt[i] = 0;
        end
        push_action(ACT_DONE, '0, '0, '0, 1'b1);
    endfunction

    function automatic host_item_t make_msg(int k);
        host_item_t it;
        it.mode = 0; it.sw = key_sw[k]; it.rdy = 1; it.ip = key_ip[k];
        it.mac = key_mac[k]; it.now = clock_s;
        return it;
    endfunction

    function automatic host_item_t make_tick(bit [TIME_W-1:0] t);
        host_item_t it;
        it = '{default: 0};
        it.mode = 1; it.now = t;
        // The payload is don't-care on a tick; scramble it anyway.
        it.sw = SW_W'($urandom); it.ip = $urandom;
        it.mac = MAC_W'({$urandom, $urandom});
        it.rdy = 1'($urandom);
        return it;
    endfunction

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_THRESHOLD: thr_q = val[CNT_W-1:0];
            REG_START:     start_lim_q = val[RUN_W-1:0];
            REG_STOP:      stop_lim_q = val[RUN_W-1:0];
            REG_TIMEOUT:   timeout_q = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the queue to drain, every action to arrive, and a tail for
    // messages still walking the table without a result.
    task automatic settle();
        @(posedge clk);
        while (host_items.size() != 0 || start || pending_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic run_phase(int nkeys, int nitems);
        host_item_t it;
        for (int n = 0; n < nitems; n++) begin
            int r;
            r = $urandom_range(99);
            if (r < 62) begin
                it = make_msg($urandom_range(nkeys - 1));
            end
            else if (r < 72) begin
                // Noise: fully random message, mostly ignored or a stray key.
                it.mode = 0; it.sw = SW_W'($urandom); it.rdy = 1'($urandom);
                it.ip = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom);
                case ($urandom_range(3))
                    0: it.mac = '0;
                    1: it.mac = MAC_BCAST;
                    default: it.mac = MAC_W'({$urandom, $urandom});
                endcase
                it.now = clock_s;
            end
            else begin
                if ($urandom_range(19) == 0)
                    clock_s = $urandom;
                else
                    clock_s = clock_s + $urandom_range(12);
                it = make_tick(clock_s);
            end
            host_items.push_back(it);
        end
        settle();
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: changes inputs on the falling edge.
    always @(negedge clk) begin
        host_item_t it;
        bit         hold_off;
        if (rst_n && !(start && !took)) begin
            hold_off = !(beats_sent >= 200 && beats_sent < 280) &&
                       ($urandom_range(99) < 31);
            if (host_items.size() != 0 && !hold_off) begin
                it = host_items.pop_front();
                mode <= it.mode; switch_id <= it.sw; switch_ready <= it.rdy;
                host_ip <= it.ip; host_mac <= it.mac; now_seconds <= it.now;
                start <= 1'b1;
            end
            else begin
                start <= 1'b0;
            end
        end
        took = 1'b0;
    end

    // Acceptance, prediction, result check and watchdog on the rising edge.
    always @(posedge clk) begin
        host_item_t   it;
        host_action_t ex;
        bit           moved;
        moved = 0;
        if (rst_n && start && !busy) begin
            it.mode = mode; it.sw = switch_id; it.rdy = switch_ready;
            it.ip = host_ip; it.mac = host_mac; it.now = now_seconds;
            predict_table_update(it);
            took = 1'b1;
            beats_sent++;
            moved = 1;
        end
        if (rst_n && cfg_valid && cfg_ready)
            moved = 1;
        if (rst_n && result_valid) begin
            moved = 1;
            if (pending_actions.size() == 0) begin
                $display("%t: unexpected result act=%0d sw=%0h ip=%0h mac=%0h last=%0b",
                         $time, action, out_switch, out_ip, out_mac, last);
                errors++;
            end
            else begin
                ex = pending_actions.pop_front();
                if (action !== ex.act || out_switch !== ex.sw || out_ip !== ex.ip ||
                    out_mac !== ex.mac || last !== ex.last) begin
                    $display("%t: mismatch expected act=%0d sw=%0h ip=%0h mac=%0h last=%0b",
                             $time, ex.act, ex.sw, ex.ip, ex.mac, ex.last);
                    $display("%t:          actual   act=%0d sw=%0h ip=%0h mac=%0h last=%0b",
                             $time, action, out_switch, out_ip, out_mac, last);
                    errors++;
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        host_item_t it;
        rst_n = 1'b0; start = 1'b0; mode = 1'b0; switch_id = '0; switch_ready = 1'b0;
        host_ip = '0; host_mac = '0; now_seconds = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        errors = 0; beats_sent = 0; took = 0; quiet_cycles = 0; clock_s = 0;
        thr_q = THRESHOLD_RST; start_lim_q = START_RST; stop_lim_q = STOP_RST;
        timeout_q = TIMEOUT_RST;
        for (int i = 0; i < DEPTH; i++) begin
            hv[i] = 0; hsw[i] = 0; hip[i] = 0; hmac[i] = 0; hcnt[i] = 0;
            horun[i] = 0; hqrun[i] = 0; hblk[i] = 0; hstamp[i] = 0;
        end
        for (int k = 0; k < NKEYS; k++) begin
            key_sw[k] = SW_W'($urandom);
            key_ip[k] = $urandom | 32'h1;
            key_mac[k] = (MAC_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFFE)
                         | 48'h1_0000;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings. Ignored messages first.
        it = make_msg(0); it.rdy = 0;          host_items.push_back(it);
        it = make_msg(0); it.ip = 0;           host_items.push_back(it);
        it = make_msg(0); it.mac = 0;          host_items.push_back(it);
        it = make_msg(0); it.mac = MAC_BCAST;  host_items.push_back(it);
        it = make_msg(0); it.sw = 8'hFF; it.ip = '1; it.mac = 48'hFFFF_FFFF_FFFE;
        host_items.push_back(it);
        it = make_msg(0); it.sw = 0; it.ip = 1; it.mac = 1;
        host_items.push_back(it);
        host_items.push_back(it);
        host_items.push_back(make_tick(0));
        // Idle longer than the timeout frees both entries.
        host_items.push_back(make_tick(400));
        clock_s = 1000;
        host_items.push_back(make_msg(1));
        host_items.push_back(make_tick(1000));
        // The clock going backwards frees an idle entry too.
        host_items.push_back(make_tick(5));
        host_items.push_back(make_tick('1));
        clock_s = 10;
        settle();

        write_reg(REG_THRESHOLD, 2); write_reg(REG_START, 2);
        write_reg(REG_STOP, 1); write_reg(REG_TIMEOUT, 5);
        run_phase(4, 80);

        write_reg(REG_THRESHOLD, 0); write_reg(REG_START, 0);
        write_reg(REG_STOP, 0); write_reg(REG_TIMEOUT, 0);
        run_phase(6, 50);

        // Fill the table past its depth so that drops show up.
        write_reg(REG_THRESHOLD, 1); write_reg(REG_START, 1);
        write_reg(REG_STOP, 2); write_reg(REG_TIMEOUT, 10);
        for (int k = 0; k < DEPTH + 2; k++)
            host_items.push_back(make_msg(k));
        run_phase(NKEYS, 60);

        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF); write_reg(REG_START, 255);
        write_reg(REG_STOP, 255); write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        run_phase(8, 50);

        write_reg(REG_THRESHOLD, 3); write_reg(REG_START, 3);
        write_reg(REG_STOP, 3); write_reg(REG_TIMEOUT, 20);
        run_phase(4, 80);

        // An index past the last register must leave the settings alone.
        write_reg(8'd7, 32'h5A5A_5A5A); write_reg(8'hFF, 32'hFFFF_FFFF);
        write_reg(REG_THRESHOLD, 1); write_reg(REG_START, 1);
        write_reg(REG_STOP, 1); write_reg(REG_TIMEOUT, 3);
        run_phase(12, 80);

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/hod_pkg.sv
rtl/core/host_overload_detector.sv
rtl/core/hod_checker.sv
tb/tb_top.sv
